// File: src/vnsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnsc_pkg
// shared types, widths and codes for the nearest seed colour block
// ----------------------------------------------------------------------------
package vnsc_pkg;

    localparam int COORD_BITS    = 8;
    localparam int COLOUR_BITS   = 8;
    localparam int IDX_BITS      = 3;
    localparam int CFG_BITS      = 4;
    localparam int DIST_BITS     = 2 * COORD_BITS + 1;
    localparam int MAX_SEEDS_DEF = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [IDX_BITS-1:0]    seed_index;
        logic [COORD_BITS-1:0]  seed_x;
        logic [COORD_BITS-1:0]  seed_y;
        logic [COLOUR_BITS-1:0] seed_red;
        logic [COLOUR_BITS-1:0] seed_green;
        logic [COLOUR_BITS-1:0] seed_blue;
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [IDX_BITS-1:0]    nearest_index;
        logic [DIST_BITS-1:0]   nearest_distance;
        logic [COLOUR_BITS-1:0] out_red;
        logic [COLOUR_BITS-1:0] out_green;
        logic [COLOUR_BITS-1:0] out_blue;
    } t_out_item;

    typedef struct packed {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] blue;
    } t_seed;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

endpackage

// File: src/vnsc_seed_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnsc_seed_mem
// seed table: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module vnsc_seed_mem
    import vnsc_pkg::*;
#(
    parameter int MAX_SEEDS = MAX_SEEDS_DEF,
    localparam int IW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_seed         i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_seed         o_rdata
);

    t_seed r_mem [MAX_SEEDS];
    t_seed r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vnsc_sq_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnsc_sq_serial
// bit-serial shift-add squarer, one operand bit per cycle
// ----------------------------------------------------------------------------
module vnsc_sq_serial
    import vnsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [COORD_BITS-1:0]     i_operand,
    output logic                      o_busy,
    output logic [2*COORD_BITS-1:0]   o_square
);

    localparam int CW = $clog2(COORD_BITS + 1);

    logic                    r_busy;
    logic [CW-1:0]           r_cnt;
    logic [COORD_BITS-1:0]   r_mcand;
    logic [2*COORD_BITS-1:0] r_prod;
    logic [COORD_BITS:0]     n_sum;

    always_comb begin
        n_sum = {1'b0, r_prod[2*COORD_BITS-1:COORD_BITS]}
              + (r_prod[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(COORD_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_operand;
            r_prod  <= {{COORD_BITS{1'b0}}, i_operand};
        end else if (r_busy) begin
            r_prod <= {n_sum, r_prod[COORD_BITS-1:1]};
        end
    end

    assign o_busy   = r_busy;
    assign o_square = r_prod;

endmodule

// File: src/voronoi_nearest_seed_colour.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_colour
// a query scans the searched seeds in turn through the bit-serial squarers,
// which take one coordinate bit per cycle for each seed
// a seed write is taken while idle and gives no item
// one query at a time; the next item is taken while a result waits on stall
// synchronous active-low reset: idle, no result pending, seed_count = 1
// seed table contents are undefined until written
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_colour
    import vnsc_pkg::*;
#(
    parameter int MAX_SEEDS = MAX_SEEDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata
);

    localparam int IW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

    t_state                  r_state;
    t_state                  n_state;
    logic [CFG_BITS-1:0]     r_cfg_count;
    logic [COORD_BITS-1:0]   r_px;
    logic [COORD_BITS-1:0]   r_py;
    logic [IW-1:0]           r_scan;
    logic [IW-1:0]           r_last;
    logic [IW-1:0]           n_last;
    logic [IW-1:0]           r_best_idx;
    logic [DIST_BITS-1:0]    r_best_dist;
    t_seed                   r_best_seed;
    t_out_item               r_out;
    logic                    r_out_valid;

    logic                    in_accept;
    logic                    mem_we;
    logic                    query_start;
    logic                    sq_start;
    logic                    cmp_step;
    logic                    out_load;
    logic                    best_take;
    t_seed                   wr_seed;
    t_seed                   rd_seed;
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic                    sqx_busy;
    logic                    sqy_busy;
    logic [2*COORD_BITS-1:0] sqx;
    logic [2*COORD_BITS-1:0] sqy;
    logic [DIST_BITS-1:0]    dist_sum;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign mem_we      = in_accept && (i_in_item.op == OP_WRITE)
                      && (int'(i_in_item.seed_index) < MAX_SEEDS);
    assign query_start = in_accept && (i_in_item.op == OP_QUERY);

    assign wr_seed.x     = i_in_item.seed_x;
    assign wr_seed.y     = i_in_item.seed_y;
    assign wr_seed.red   = i_in_item.seed_red;
    assign wr_seed.green = i_in_item.seed_green;
    assign wr_seed.blue  = i_in_item.seed_blue;

    vnsc_seed_mem #(
        .MAX_SEEDS (MAX_SEEDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (IW'(i_in_item.seed_index)),
        .i_wdata (wr_seed),
        .i_raddr (r_scan),
        .o_rdata (rd_seed)
    );

    // absolute coordinate differences
    always_comb begin
        dx = (rd_seed.x >= r_px) ? (rd_seed.x - r_px) : (r_px - rd_seed.x);
        dy = (rd_seed.y >= r_py) ? (rd_seed.y - r_py) : (r_py - rd_seed.y);
    end

    vnsc_sq_serial u_sqx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (dx),
        .o_busy    (sqx_busy),
        .o_square  (sqx)
    );

    vnsc_sq_serial u_sqy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (dy),
        .o_busy    (sqy_busy),
        .o_square  (sqy)
    );

    assign dist_sum  = {1'b0, sqx} + {1'b0, sqy};
    assign best_take = (r_scan == '0) || (dist_sum < r_best_dist);

    // clamp of the searched entry count
    always_comb begin
        if (r_cfg_count == '0) begin
            n_last = '0;
        end else if (int'(r_cfg_count) > MAX_SEEDS) begin
            n_last = IW'(MAX_SEEDS - 1);
        end else begin
            n_last = IW'(r_cfg_count - 1'b1);
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        sq_start   = 1'b0;
        cmp_step   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && (i_in_item.op == OP_QUERY)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                sq_start = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                if (!sqx_busy && !sqy_busy) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                cmp_step = 1'b1;
                n_state  = (r_scan == r_last) ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_count <= CFG_BITS'(1);
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_wdata;
            end
            if (query_start) begin
                r_scan <= '0;
            end else if (cmp_step && (r_scan != r_last)) begin
                r_scan <= r_scan + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_start) begin
            r_px   <= i_in_item.pixel_x;
            r_py   <= i_in_item.pixel_y;
            r_last <= n_last;
        end
        if (cmp_step && best_take) begin
            r_best_idx  <= r_scan;
            r_best_dist <= dist_sum;
            r_best_seed <= rd_seed;
        end
        if (out_load) begin
            r_out.nearest_index    <= IDX_BITS'(r_best_idx);
            r_out.nearest_distance <= r_best_dist;
            r_out.out_red          <= r_best_seed.red;
            r_out.out_green        <= r_best_seed.green;
            r_out.out_blue         <= r_best_seed.blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
